FILE: hdl/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// Shared constants, codes and types of the frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

    // bitmap geometry
    localparam int MAX_FRAMES  = 32768;
    localparam int WORD_BITS   = 32;
    localparam int MAP_WORDS   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW     = $clog2(MAP_WORDS);
    localparam int BIT_AW      = $clog2(WORD_BITS);
    localparam int FRAME_W     = WORD_AW + BIT_AW;
    localparam int COUNT_W     = FRAME_W + 1;
    localparam int LEN_W       = 16;
    localparam int ADDR_W      = 27;
    localparam int FRAME_SHIFT = 12;
    localparam int MODE_W      = 3;

    // field widths of the stream beats
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 24;

    // register map
    localparam int REG_IDX_W   = 1;
    localparam int PADDR_W     = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_COUNT = 1'b0;
    localparam logic [15:0] FRAME_COUNT_RESET = 16'd32768;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_TEST  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIND  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RUN   = 3'd5;

    typedef logic [WORD_BITS-1:0] word_t;

    // scan unit control from the sequencer
    typedef struct packed {
        logic clear;   // start of a search: drop the carried run
        logic ld;      // memory word valid: evaluate first half
        logic step;    // word done: carry the run into the next word
    } scan_ctl_t;

    // scan unit verdict for the current word
    typedef struct packed {
        logic               hit;
        logic [BIT_AW-1:0]  pos;
        logic [FRAME_W-1:0] start;
    } scan_res_t;

endpackage

FILE: hdl/fba_scan.sv
// ----------------------------------------------------------------------------
// fba_scan
// Free-run search over one bitmap word, carrying the free run across words.
// ----------------------------------------------------------------------------
module fba_scan
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fba_pkg::scan_ctl_t            ctl,
    input  fba_pkg::word_t                rd_word,
    input  logic [fba_pkg::WORD_AW-1:0]   word_idx,
    input  logic [fba_pkg::COUNT_W-1:0]   eff_count,
    input  logic [fba_pkg::LEN_W-1:0]     run_len,
    output fba_pkg::scan_res_t            res
);

    localparam int SH_W = fba_pkg::BIT_AW + 1;

    fba_pkg::word_t              limit;
    fba_pkg::word_t              used;
    fba_pkg::word_t              free_bits;
    fba_pkg::word_t              dbl [0:fba_pkg::BIT_AW];
    fba_pkg::word_t              acc;
    fba_pkg::word_t              win;
    fba_pkg::word_t              below;
    logic [SH_W-1:0]             off;
    logic [fba_pkg::BIT_AW-1:0]  hi_used;
    logic [SH_W-1:0]             lead;
    logic [fba_pkg::COUNT_W:0]   rem;

    fba_pkg::word_t              win_reg;
    fba_pkg::word_t              below_reg;
    logic [SH_W-1:0]             lead_reg;
    logic                        all_free_reg;
    logic [fba_pkg::LEN_W-1:0]   run_reg;
    logic [fba_pkg::LEN_W-1:0]   run_next;

    logic [fba_pkg::LEN_W:0]     need;
    fba_pkg::word_t              ge_mask;
    fba_pkg::word_t              cand;
    logic [fba_pkg::BIT_AW-1:0]  pos;
    logic [fba_pkg::LEN_W-1:0]   start_full;

    // first half: mask frames past the count, find in-word windows
    always_comb
    begin
        rem = {1'b0, eff_count} - {2'b00, word_idx, {fba_pkg::BIT_AW{1'b0}}};
        if (rem[fba_pkg::COUNT_W:fba_pkg::BIT_AW] != '0)
            limit = '0;
        else
            limit = {fba_pkg::WORD_BITS{1'b1}} << rem[fba_pkg::BIT_AW-1:0];
        used      = rd_word | limit;
        free_bits = ~used;

        // dbl[i] bit p: 2**i free frames ending at p, all inside the word
        dbl[0] = free_bits;
        for (int i = 1; i <= fba_pkg::BIT_AW; i++)
            dbl[i] = dbl[i-1] & (dbl[i-1] << (2 ** (i - 1)));

        // combine the powers of two that make up the run length
        acc = {fba_pkg::WORD_BITS{1'b1}};
        off = '0;
        for (int i = 0; i <= fba_pkg::BIT_AW; i++)
        begin
            if (run_len[i])
            begin
                acc = acc & (dbl[i] << off);
                off = off + SH_W'(2 ** i);
            end
        end
        if (run_len != '0 && run_len <= fba_pkg::LEN_W'(fba_pkg::WORD_BITS))
            win = acc;
        else
            win = '0;

        // free frames below the lowest used one
        below = (used & (~used + fba_pkg::word_t'(1))) - fba_pkg::word_t'(1);

        // highest used frame gives the free tail of the word
        hi_used = '0;
        for (int i = 0; i < fba_pkg::WORD_BITS; i++)
        begin
            if (used[i])
                hi_used = fba_pkg::BIT_AW'(i);
        end
        if (used == '0)
            lead = SH_W'(fba_pkg::WORD_BITS);
        else
            lead = SH_W'(fba_pkg::WORD_BITS - 1) - {1'b0, hi_used};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld)
        begin
            win_reg      <= win;
            below_reg    <= below;
            lead_reg     <= lead;
            all_free_reg <= (used == '0);
        end
    end

    // second half: in-word windows and runs that start in earlier words
    always_comb
    begin
        need = {1'b0, run_len} - {1'b0, run_reg} - (fba_pkg::LEN_W+1)'(1);
        if (need[fba_pkg::LEN_W])
            ge_mask = {fba_pkg::WORD_BITS{1'b1}};
        else if (need[fba_pkg::LEN_W-1:fba_pkg::BIT_AW] != '0)
            ge_mask = '0;
        else
            ge_mask = {fba_pkg::WORD_BITS{1'b1}} << need[fba_pkg::BIT_AW-1:0];

        cand = win_reg | (below_reg & ge_mask);

        pos = '0;
        for (int i = fba_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (cand[i])
                pos = fba_pkg::BIT_AW'(i);
        end

        start_full = fba_pkg::LEN_W'({word_idx, pos}) + fba_pkg::LEN_W'(1) - run_len;

        res.hit   = (cand != '0);
        res.pos   = pos;
        res.start = start_full[fba_pkg::FRAME_W-1:0];
    end

    // carried free run
    always_comb
    begin
        run_next = run_reg;
        if (ctl.clear)
            run_next = '0;
        else if (ctl.step)
        begin
            if (all_free_reg)
                run_next = run_reg + fba_pkg::LEN_W'(fba_pkg::WORD_BITS);
            else
                run_next = fba_pkg::LEN_W'(lead_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_reg <= '0;
        else
            run_reg <= run_next;
    end

endmodule

FILE: hdl/frame_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_core
// Bitmap allocator for 4 KiB frames: test, set, clear, find, allocate, run.
//
//   channel   dir  handshake                       beat
//   s_axis    in   s_axis_tvalid / s_axis_tready   mode, frame_address, run_length
//   m_axis    out  m_axis_tvalid / m_axis_tready   frame_number, found, was_used,
//                                                  in_range
//   apb       in   psel, penable, pwrite, pready   frame_count at offset 0
//
// Test, set and clear pass through read, modify/write-back and result states.
// A search reads one bitmap word at a time (read, evaluation, run carry),
// up to ceil(min(frame_count, 32768)/32) words.
// After reset a clearing pass zeroes the bitmap; no beat is taken
// meanwhile, register writes are. One result waits in the output register
// while the next beat is taken; completion stalls while that register is full.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_core
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [2:0] mode, [29:3] frame_address, [45:30] run_length, [47:46] zero
    input  logic [fba_pkg::IN_DATA_W-1:0]     s_axis_tdata,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [14:0] frame_number, [15] found, [16] was_used, [17] in_range, [23:18] zero
    output logic [fba_pkg::OUT_DATA_W-1:0]    m_axis_tdata,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fba_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_BRD  = 3'd2;
    localparam logic [2:0] ST_BWB  = 3'd3;
    localparam logic [2:0] ST_SRD  = 3'd4;
    localparam logic [2:0] ST_SEV1 = 3'd5;
    localparam logic [2:0] ST_SEV2 = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    localparam int RES_W = fba_pkg::FRAME_W + 3;

    // state and request
    logic [2:0]                     state_reg, state_next;
    logic [fba_pkg::WORD_AW-1:0]    word_reg, word_next;
    logic [fba_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic [fba_pkg::FRAME_W-1:0]    frame_reg, frame_next;
    logic [fba_pkg::LEN_W-1:0]      len_reg, len_next;

    // pending result and output register
    logic [fba_pkg::FRAME_W-1:0]    fnum_reg, fnum_next;
    logic                           found_reg, found_next;
    logic                           used_reg, used_next;
    logic                           inr_reg, inr_next;
    logic                           out_valid_reg, out_valid_next;
    logic [RES_W-1:0]               out_data_reg, out_data_next;

    logic [15:0]                    frame_count_reg;
    logic [fba_pkg::COUNT_W-1:0]    eff_count;
    logic [fba_pkg::COUNT_W-1:0]    eff_m1;
    logic [fba_pkg::WORD_AW-1:0]    last_word;

    // bitmap memory ports
    fba_pkg::word_t                 bitmap_mem [0:fba_pkg::MAP_WORDS-1];
    fba_pkg::word_t                 mem_rdata_reg;
    logic                           mem_we;
    logic [fba_pkg::WORD_AW-1:0]    mem_waddr;
    fba_pkg::word_t                 mem_wdata;
    logic                           mem_re;
    logic [fba_pkg::WORD_AW-1:0]    mem_raddr;

    fba_pkg::scan_ctl_t             scan_ctl;
    fba_pkg::scan_res_t             scan_res;

    logic                           in_beat;
    logic [fba_pkg::MODE_W-1:0]     in_mode;
    logic [fba_pkg::ADDR_W-1:0]     in_addr;
    logic [fba_pkg::LEN_W-1:0]      in_len;
    logic [fba_pkg::LEN_W-1:0]      in_len_eff;
    logic                           frame_inr;
    logic                           bit_was;
    fba_pkg::word_t                 bit_mask;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[fba_pkg::PADDR_W-1:2] == fba_pkg::REG_FRAME_COUNT)
                  ? {16'd0, frame_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_count_reg <= fba_pkg::FRAME_COUNT_RESET;
        else if (psel && penable && pwrite && pready
                 && paddr[fba_pkg::PADDR_W-1:2] == fba_pkg::REG_FRAME_COUNT)
            frame_count_reg <= pwdata[15:0];
    end

    // effective frame count and last word to scan
    always_comb
    begin
        if (frame_count_reg > 16'(fba_pkg::MAX_FRAMES))
            eff_count = fba_pkg::COUNT_W'(fba_pkg::MAX_FRAMES);
        else
            eff_count = fba_pkg::COUNT_W'(frame_count_reg);
        eff_m1    = eff_count - fba_pkg::COUNT_W'(1);
        last_word = eff_m1[fba_pkg::FRAME_W-1:fba_pkg::BIT_AW];
    end

    // input beat fields
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign in_mode       = s_axis_tdata[fba_pkg::MODE_W-1:0];
    assign in_addr       = s_axis_tdata[fba_pkg::MODE_W +: fba_pkg::ADDR_W];
    assign in_len        = s_axis_tdata[fba_pkg::MODE_W + fba_pkg::ADDR_W +: fba_pkg::LEN_W];
    assign in_len_eff    = (in_mode == fba_pkg::MODE_RUN) ? in_len : fba_pkg::LEN_W'(1);

    // single-frame access
    assign frame_inr = ({1'b0, frame_reg} < eff_count);
    assign bit_mask  = fba_pkg::word_t'(1) << frame_reg[fba_pkg::BIT_AW-1:0];
    assign bit_was   = frame_inr ? ((mem_rdata_reg & bit_mask) != '0) : 1'b1;

    // bitmap memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            bitmap_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= bitmap_mem[mem_raddr];
    end

    fba_scan u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .rd_word   (mem_rdata_reg),
        .word_idx  (word_reg),
        .eff_count (eff_count),
        .run_len   (len_reg),
        .res       (scan_res)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        word_next      = word_reg;
        mode_next      = mode_reg;
        frame_next     = frame_reg;
        len_next       = len_reg;
        fnum_next      = fnum_reg;
        found_next     = found_reg;
        used_next      = used_reg;
        inr_next       = inr_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = word_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = word_reg;
        scan_ctl       = '0;

        unique case (state_reg)
            ST_CLR:
            begin
                mem_we    = 1'b1;
                word_next = word_reg + fba_pkg::WORD_AW'(1);
                if (word_reg == fba_pkg::WORD_AW'(fba_pkg::MAP_WORDS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    mode_next  = in_mode;
                    frame_next = in_addr[fba_pkg::FRAME_SHIFT +: fba_pkg::FRAME_W];
                    len_next   = in_len_eff;
                    fnum_next  = '0;
                    found_next = 1'b0;
                    used_next  = 1'b0;
                    inr_next   = 1'b0;
                    case (in_mode) inside
                        fba_pkg::MODE_TEST, fba_pkg::MODE_SET, fba_pkg::MODE_CLEAR:
                            state_next = ST_BRD;
                        fba_pkg::MODE_FIND, fba_pkg::MODE_ALLOC, fba_pkg::MODE_RUN:
                        begin
                            if (in_len_eff == '0)
                            begin
                                found_next = (eff_count != '0);
                                inr_next   = (eff_count != '0);
                                state_next = ST_DONE;
                            end
                            else if (eff_count == '0)
                                state_next = ST_DONE;
                            else
                            begin
                                scan_ctl.clear = 1'b1;
                                word_next      = '0;
                                state_next     = ST_SRD;
                            end
                        end
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_BRD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = frame_reg[fba_pkg::FRAME_W-1:fba_pkg::BIT_AW];
                state_next = ST_BWB;
            end
            ST_BWB:
            begin
                mem_waddr = frame_reg[fba_pkg::FRAME_W-1:fba_pkg::BIT_AW];
                if (frame_inr && mode_reg == fba_pkg::MODE_SET)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata_reg | bit_mask;
                end
                else if (frame_inr && mode_reg == fba_pkg::MODE_CLEAR)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata_reg & ~bit_mask;
                end
                fnum_next  = frame_reg;
                used_next  = bit_was;
                inr_next   = frame_inr;
                state_next = ST_DONE;
            end
            ST_SRD:
            begin
                mem_re     = 1'b1;
                state_next = ST_SEV1;
            end
            ST_SEV1:
            begin
                scan_ctl.ld = 1'b1;
                state_next  = ST_SEV2;
            end
            ST_SEV2:
            begin
                scan_ctl.step = 1'b1;
                if (scan_res.hit)
                begin
                    fnum_next  = scan_res.start;
                    found_next = 1'b1;
                    inr_next   = 1'b1;
                    if (mode_reg == fba_pkg::MODE_ALLOC)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = mem_rdata_reg | (fba_pkg::word_t'(1) << scan_res.pos);
                    end
                    state_next = ST_DONE;
                end
                else if (word_reg == last_word)
                    state_next = ST_DONE;
                else
                begin
                    word_next  = word_reg + fba_pkg::WORD_AW'(1);
                    state_next = ST_SRD;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {inr_reg, used_reg, found_reg, fnum_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        frame_reg    <= frame_next;
        len_reg      <= len_next;
        fnum_reg     <= fnum_next;
        found_reg    <= found_next;
        used_reg     <= used_next;
        inr_reg      <= inr_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(fba_pkg::OUT_DATA_W - RES_W)'(0), out_data_reg};

`ifndef NO_ASSERTIONS
    // clearing pass writes zeros and never takes a beat
    a_clr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLR) |-> (mem_we && mem_wdata == '0 && !s_axis_tready))
        else $error("clearing pass wrote non-zero data or took a beat");

    // a scan never reads past the last word in range
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRD) |-> (word_reg <= last_word))
        else $error("scan ran past the last bitmap word");

    // a successful set leaves the frame marked used in the written word
    a_set_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BWB && frame_inr && mode_reg == fba_pkg::MODE_SET)
        |-> (mem_we && (mem_wdata & bit_mask) != '0))
        else $error("set did not write the frame bit");

    // a found frame lies below the frame count
    a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[fba_pkg::FRAME_W])
        |-> ({1'b0, m_axis_tdata[fba_pkg::FRAME_W-1:0]} < eff_count))
        else $error("found frame beyond the frame count");

    // a new result is loaded only into an empty or draining output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> $stable(out_data_reg))
        else $error("pending result overwritten");
`endif

endmodule
